### rtl/hashed_timer_wheel_assert.svh
// Assertion macros for the hashed timer wheel.
// Users must have clk and rst in scope; define NO_ASSERTIONS to drop the checks.
`ifndef HASHED_TIMER_WHEEL_ASSERT_SVH
`define HASHED_TIMER_WHEEL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HTW_ASSERT_SAME(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);
`define HTW_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);
`else
`define HTW_ASSERT_SAME(label, ant, cons, msg)
`define HTW_ASSERT_NEXT(label, ant, cons, msg)
`endif
`endif

### rtl/htw_pkg.sv
// Shared types and codes for the hashed timer wheel.
// No dependencies; every module and interface imports this package.
package htw_pkg;

  // Slot count of the wheel. It is a power of two, so the slot offset of a period is its
  // low bits and the number of rounds is a shift.
  localparam int SLOTS     = 8;
  localparam int SLOT_BITS = $clog2(SLOTS);

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_TICK       = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_REMOVED  = 3'd2,
    KIND_EXPIRED  = 3'd3,
    KIND_IDLE     = 3'd4
  } kind_t;

  // Per-cell controls: shift has priority over load, load over clear.
  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } cell_ctl_t;

endpackage

### rtl/htw_if.sv
// Valid/ready channel interfaces for the hashed timer wheel requests and results.
// Depends on htw_pkg for the result kind type.
interface htw_req_if import htw_pkg::*; #(
  parameter int IDW = 4,
  parameter int PB  = 16
);
  logic           valid;
  logic           ready;
  logic [1:0]     opcode;
  logic [IDW-1:0] timer_id;
  logic [PB-1:0]  period;

  modport source (output valid, output opcode, output timer_id, output period, input ready);
  modport sink (input valid, input opcode, input timer_id, input period, output ready);
endinterface

interface htw_rsp_if import htw_pkg::*; #(
  parameter int IDW = 4,
  parameter int SB  = 3
);
  logic           valid;
  logic           ready;
  kind_t          kind;
  logic [IDW-1:0] timer_id_res;
  logic [SB-1:0]  slot;
  logic           last;

  modport source (output valid, output kind, output timer_id_res, output slot,
                  output last, input ready);
  modport sink (input valid, input kind, input timer_id_res, input slot,
                input last, output ready);
endinterface

### rtl/htw_cell.sv
// One timer entry of the wheel: armed flag, slot, remaining rounds, reload value and slot offset.
// Depends on htw_pkg for the cell control struct.
module htw_cell import htw_pkg::*; #(
  parameter int SB = 3,
  parameter int PB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctl_t     ctl,
  input  logic          shin_valid,
  input  logic [SB-1:0] shin_slot,
  input  logic [PB-1:0] shin_rounds,
  input  logic [PB-1:0] shin_reload,
  input  logic [SB-1:0] shin_off,
  input  logic [SB-1:0] ld_slot,
  input  logic [PB-1:0] ld_rounds,
  input  logic [SB-1:0] ld_off,
  output logic          valid,
  output logic [SB-1:0] slot,
  output logic [PB-1:0] rounds,
  output logic [PB-1:0] reload,
  output logic [SB-1:0] off
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= shin_valid;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end
  end

  // The reload value is the rounds count written at arming time.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      slot   <= shin_slot;
      rounds <= shin_rounds;
      reload <= shin_reload;
      off    <= shin_off;
    end else if (ctl.load) begin
      slot   <= ld_slot;
      rounds <= ld_rounds;
      reload <= ld_rounds;
      off    <= ld_off;
    end
  end

endmodule

### rtl/htw_div.sv
// Splits a period into wheel rounds and slot offset for the power-of-two slot count.
// Depends on htw_pkg for the slot width; purely combinational.
module htw_div import htw_pkg::*; #(
  parameter int PB = 16
) (
  input  logic [PB-1:0]        period,
  output logic [PB-1:0]        rounds,
  output logic [SLOT_BITS-1:0] off
);

  logic [PB-1:0] period_m1;

  // Rounds are (period - 1) / SLOTS so that exact multiples fire on time.
  assign period_m1 = period - 1'b1;
  assign rounds    = period_m1 >> SLOT_BITS;
  assign off       = period[SLOT_BITS-1:0];

endmodule

### rtl/hashed_timer_wheel.sv
// Hashed timer wheel: register and unregister pass through the emit state, which registers
// their result once the result side is free. A tick scans every entry as the ring of entry
// cells rotates once past the head cell, then gives its last result from the emit state;
// a scan step waits while an earlier expiry cannot be pushed. One item is in work at a time.
// Synchronous reset clears the current slot and every armed flag at once; no clearing pass
// is needed.
`include "hashed_timer_wheel_assert.svh"
module hashed_timer_wheel import htw_pkg::*; #(
  parameter int ENTRIES     = 16,
  parameter int PERIOD_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  htw_req_if.sink   req,
  htw_rsp_if.source rsp
);

  localparam int SB  = SLOT_BITS;
  localparam int PB  = PERIOD_BITS;
  localparam int IDW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam logic [SB:0]  SLOTS_L = (SB + 1)'(SLOTS);
  localparam logic [IDW:0] ENT_L   = (IDW + 1)'(ENTRIES);
  localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t         state;
  logic [SB-1:0]  cur;
  logic [CW-1:0]  cnt;
  logic           have_pend;
  kind_t          pend_kind;
  logic [IDW-1:0] pend_id;
  logic [SB-1:0]  pend_slot;

  logic            c_valid  [ENTRIES];
  logic [SB-1:0]   c_slot   [ENTRIES];
  logic [PB-1:0]   c_rounds [ENTRIES];
  logic [PB-1:0]   c_reload [ENTRIES];
  logic [SB-1:0]   c_off    [ENTRIES];
  cell_ctl_t       c_ctl    [ENTRIES];

  logic            accept;
  logic            id_ok;
  logic            out_free;
  logic            arm_load;
  logic [PB-1:0]   div_q;
  logic [SB-1:0]   ld_off;
  logic [SB:0]     arm_sum;
  logic [SB-1:0]   arm_slot;
  logic [SB:0]     cur_inc;
  logic [SB-1:0]   cur_next;

  logic            hit;
  logic            expire;
  logic [SB:0]     rearm_sum;
  logic [SB-1:0]   proc_slot;
  logic [PB-1:0]   proc_rounds;
  logic            step;
  logic            rsp_push;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign id_ok    = ({1'b0, req.timer_id} < ENT_L);
  assign out_free = !rsp.valid || rsp.ready;
  assign arm_load = accept && (req.opcode == OP_REGISTER) && id_ok && (req.period != '0);

  htw_div #(.PB(PB)) u_div (
    .period (req.period),
    .rounds (div_q),
    .off    (ld_off)
  );

  assign arm_sum  = {1'b0, cur} + {1'b0, ld_off};
  assign arm_slot = (arm_sum >= SLOTS_L) ? SB'(arm_sum - SLOTS_L) : arm_sum[SB-1:0];
  assign cur_inc  = {1'b0, cur} + 1'b1;
  assign cur_next = (cur_inc == SLOTS_L) ? '0 : cur_inc[SB-1:0];

  // Head cell: the entry now passing cell 0 is checked against the current slot.
  assign hit       = c_valid[0] && (c_slot[0] == cur);
  assign expire    = hit && (c_rounds[0] == '0);
  assign rearm_sum = {1'b0, cur} + {1'b0, c_off[0]};
  assign proc_slot = !expire ? c_slot[0] :
                     (rearm_sum >= SLOTS_L) ? SB'(rearm_sum - SLOTS_L) : rearm_sum[SB-1:0];
  assign proc_rounds = expire ? c_reload[0] : (hit ? c_rounds[0] - 1'b1 : c_rounds[0]);
  assign step = (state == ST_SCAN) && (!(expire && have_pend) || out_free);
  assign rsp_push = (step && expire && have_pend) || ((state == ST_EMIT) && out_free);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic          sin_valid;
    logic [SB-1:0] sin_slot;
    logic [PB-1:0] sin_rounds;
    logic [PB-1:0] sin_reload;
    logic [SB-1:0] sin_off;

    if (i == ENTRIES - 1) begin : g_tail
      assign sin_valid  = c_valid[0];
      assign sin_slot   = proc_slot;
      assign sin_rounds = proc_rounds;
      assign sin_reload = c_reload[0];
      assign sin_off    = c_off[0];
    end else begin : g_mid
      assign sin_valid  = c_valid[i+1];
      assign sin_slot   = c_slot[i+1];
      assign sin_rounds = c_rounds[i+1];
      assign sin_reload = c_reload[i+1];
      assign sin_off    = c_off[i+1];
    end

    assign c_ctl[i].shift = step;
    assign c_ctl[i].load  = arm_load && (req.timer_id == IDW'(i));
    assign c_ctl[i].clear = accept && (req.opcode == OP_UNREGISTER) &&
                            (req.timer_id == IDW'(i));

    htw_cell #(.SB(SB), .PB(PB)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (c_ctl[i]),
      .shin_valid  (sin_valid),
      .shin_slot   (sin_slot),
      .shin_rounds (sin_rounds),
      .shin_reload (sin_reload),
      .shin_off    (sin_off),
      .ld_slot     (arm_slot),
      .ld_rounds   (div_q),
      .ld_off      (ld_off),
      .valid       (c_valid[i]),
      .slot        (c_slot[i]),
      .rounds      (c_rounds[i]),
      .reload      (c_reload[i]),
      .off         (c_off[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      cnt       <= '0;
      have_pend <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_push) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pend_id <= req.timer_id;
            case (req.opcode)
              OP_REGISTER: begin
                if (arm_load) begin
                  pend_kind <= KIND_ACCEPTED;
                  pend_slot <= arm_slot;
                end else begin
                  pend_kind <= KIND_REJECTED;
                  pend_slot <= '0;
                end
                state <= ST_EMIT;
              end
              OP_UNREGISTER: begin
                pend_kind <= KIND_REMOVED;
                pend_slot <= '0;
                state     <= ST_EMIT;
              end
              OP_TICK: begin
                cur       <= cur_next;
                cnt       <= '0;
                have_pend <= 1'b0;
                state     <= ST_SCAN;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (step) begin
            cnt <= cnt + 1'b1;
            // An earlier expiry is known not to be the final result once another appears.
            if (expire) begin
              if (have_pend) begin
                rsp.kind         <= pend_kind;
                rsp.timer_id_res <= pend_id;
                rsp.slot         <= pend_slot;
                rsp.last         <= 1'b0;
              end
              have_pend <= 1'b1;
              pend_kind <= KIND_EXPIRED;
              pend_id   <= cnt[IDW-1:0];
              pend_slot <= cur;
            end else if (cnt == LAST_CNT && !have_pend) begin
              pend_kind <= KIND_IDLE;
              pend_id   <= '0;
              pend_slot <= cur;
            end
            if (cnt == LAST_CNT) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            rsp.kind         <= pend_kind;
            rsp.timer_id_res <= pend_id;
            rsp.slot         <= pend_slot;
            rsp.last         <= 1'b1;
            have_pend        <= 1'b0;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `HTW_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
  `HTW_ASSERT_NEXT(a_tick_moves, accept && req.opcode == OP_TICK, cur != $past(cur), "stuck")
  `HTW_ASSERT_NEXT(a_scan_ends, step && cnt == LAST_CNT, state == ST_EMIT, "scan overran")
  `HTW_ASSERT_SAME(a_push_free, rsp_push, out_free, "push into a full result register")

endmodule
